[rtl/nrgp_pkg.sv]
// Package for the NMEA RMC/GGA fix-record parser.
// Holds sizes, character and sentence codes, and the field-to-slot map.
// No dependencies.
package nrgp_pkg;

  localparam int SLOT_COUNT     = 15;
  localparam int SLOT_CHARS_DEF = 16;
  localparam int SLOT_W         = 4;
  localparam int POS_W          = 5;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_RMC    = 2'd2;
  localparam logic [1:0] KIND_GGA    = 2'd3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  localparam logic [47:0] HDR_RMC = 48'h244750524D43;
  localparam logic [47:0] HDR_GGA = 48'h244750474741;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } slot_sel_t;

  function automatic slot_sel_t slot_map(input logic [1:0] kind, input logic [POS_W-1:0] pos);
    slot_sel_t r;
    r.hit  = 1'b0;
    r.slot = '0;
    if (kind == KIND_RMC) begin
      r.hit = 1'b1;
      case (pos)
        5'd1: r.slot = 4'd1;
        5'd3: r.slot = 4'd2;
        5'd4: r.slot = 4'd3;
        5'd5: r.slot = 4'd4;
        5'd6: r.slot = 4'd5;
        5'd7: r.slot = 4'd9;
        5'd8: r.slot = 4'd10;
        5'd9: r.slot = 4'd0;
        default: r.hit = 1'b0;
      endcase
    end else if (kind == KIND_GGA) begin
      r.hit = 1'b1;
      case (pos)
        5'd6:  r.slot = 4'd6;
        5'd7:  r.slot = 4'd7;
        5'd8:  r.slot = 4'd8;
        5'd9:  r.slot = 4'd11;
        5'd10: r.slot = 4'd12;
        5'd11: r.slot = 4'd13;
        5'd12: r.slot = 4'd14;
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

[rtl/nrgp_if.sv]
// Valid/ready channel interfaces for the parser: text input and chunk output.
// No dependencies.
interface nrgp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       batch_end;

  modport source (output valid, text_byte, batch_end, input ready);
  modport sink (input valid, text_byte, batch_end, output ready);
endinterface

interface nrgp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  slot_index;
  logic        chunk_number;
  logic [63:0] chunk_text;
  logic [3:0]  chunk_bytes;
  logic        slot_truncated;
  logic        record_last;

  modport source (output valid, slot_index, chunk_number, chunk_text, chunk_bytes,
                  slot_truncated, record_last, input ready);
  modport sink (input valid, slot_index, chunk_number, chunk_text, chunk_bytes,
                slot_truncated, record_last, output ready);
endinterface

[rtl/nrgp_slot_mem.sv]
// Slot character store: 64-bit rows of eight characters, byte-lane write,
// registered read. No dependencies.
module nrgp_slot_mem #(
  parameter int DEPTH  = 30,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [2:0]        wr_lane,
  input  logic [7:0]        wr_byte,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]       rd_data
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/nmea_rmc_gga_fix_record_parser.sv]
// NMEA RMC/GGA fix-record parser: one text byte per cycle, record of 15 slots
// emitted as 8-byte chunks on the byte that closes a batch.
// After the batch_end transaction, a clear state, a memory read and an output load
// come before the first chunk is valid. Throughput: 1 byte per cycle, input stalled
// during emission; each chunk takes a memory read, then an output load held until free.
// Reset: parse state, slot lengths and truncation flags cleared; character rows
// are not cleared, bytes past a slot's length are masked on output.
// Depends on nrgp_pkg, nrgp_if, nrgp_slot_mem.
module nmea_rmc_gga_fix_record_parser #(
  parameter int SLOT_CHARS = nrgp_pkg::SLOT_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  nrgp_in_if.sink             in_ch,
  nrgp_out_if.source          out_ch
);

  localparam int CHUNKS = (SLOT_CHARS + 7) / 8;
  localparam int DEPTH  = nrgp_pkg::SLOT_COUNT * CHUNKS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(SLOT_CHARS + 1);
  localparam int SW     = nrgp_pkg::SLOT_W;
  localparam int PW     = nrgp_pkg::POS_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_LD    = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [47:0] hdr_r, hdr_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic        chk_r, chk_nxt;
  logic        rmc_r, rmc_nxt;
  logic        gga_r, gga_nxt;

  logic [LEN_W-1:0] slot_len_r [nrgp_pkg::SLOT_COUNT];
  logic             slot_ovf_r [nrgp_pkg::SLOT_COUNT];

  logic [SW-1:0] emit_slot_r;
  logic          emit_chunk_r;

  logic        out_valid_r;
  logic [3:0]  out_slot_r;
  logic        out_chunk_r;
  logic [63:0] out_text_r;
  logic [3:0]  out_bytes_r;
  logic        out_trunc_r;
  logic        out_last_r;

  logic [7:0] c;
  logic       in_fire, delim, is_star;
  logic       clr_en, app_en;
  nrgp_pkg::slot_sel_t clr_sel, app_sel;
  logic [LEN_W-1:0] app_len;
  logic             app_room;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [63:0]       rd_data;

  logic [LEN_W-1:0] len_e;
  logic [4:0]       len5, start5, diff5;
  logic [3:0]       cnt;
  logic [63:0]      text_m;
  logic             emit_last, out_free, load;

  assign c       = in_ch.text_byte;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign is_star = (c == nrgp_pkg::CH_STAR);
  assign delim   = (c == nrgp_pkg::CH_COMMA) || is_star;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    kind_nxt = kind_r;
    hdr_nxt  = hdr_r;
    pos_nxt  = pos_r;
    chk_nxt  = chk_r;
    rmc_nxt  = rmc_r;
    gga_nxt  = gga_r;
    clr_en   = 1'b0;
    app_en   = 1'b0;
    clr_sel  = '0;
    app_sel  = '0;
    if (in_fire) begin
      if (c == nrgp_pkg::CH_DOLLAR) begin
        kind_nxt = nrgp_pkg::KIND_HEADER;
        hdr_nxt  = 48'(nrgp_pkg::CH_DOLLAR);
        pos_nxt  = '0;
        chk_nxt  = 1'b0;
      end else if (kind_r == nrgp_pkg::KIND_HEADER) begin
        if (delim) begin
          if (hdr_r == nrgp_pkg::HDR_RMC) begin
            kind_nxt = nrgp_pkg::KIND_RMC;
            rmc_nxt  = 1'b1;
          end else if (hdr_r == nrgp_pkg::HDR_GGA) begin
            kind_nxt = nrgp_pkg::KIND_GGA;
            gga_nxt  = 1'b1;
          end else begin
            kind_nxt = nrgp_pkg::KIND_NONE;
          end
          pos_nxt = PW'(1);
          chk_nxt = is_star;
          clr_sel = nrgp_pkg::slot_map(kind_nxt, PW'(1));
          clr_en  = !is_star && clr_sel.hit;
        end else if (hdr_r[47:40] == 8'h00) begin
          hdr_nxt = {hdr_r[39:0], c};
        end
      end else if (kind_r inside {nrgp_pkg::KIND_RMC, nrgp_pkg::KIND_GGA}) begin
        if (delim) begin
          chk_nxt = chk_r || is_star;
          if (pos_r != {PW{1'b1}}) begin
            pos_nxt = pos_r + PW'(1);
          end
          clr_sel = nrgp_pkg::slot_map(kind_r, pos_nxt);
          clr_en  = !chk_nxt && clr_sel.hit;
        end else if (!chk_r) begin
          app_sel = nrgp_pkg::slot_map(kind_r, pos_r);
          app_en  = app_sel.hit;
        end
      end
    end
  end

  assign app_len  = slot_len_r[app_sel.slot];
  assign app_room = (32'(app_len) < SLOT_CHARS);
  assign wr_en    = app_en && app_room;
  assign wr_addr  = ADDR_W'(32'(app_sel.slot) * CHUNKS + 32'(app_len >> 3));

  // emission datapath
  assign len_e     = slot_len_r[emit_slot_r];
  assign len5      = 5'(len_e);
  assign start5    = {1'b0, emit_chunk_r, 3'b000};
  assign diff5     = (len5 > start5) ? (len5 - start5) : 5'd0;
  assign cnt       = (diff5 > 5'd8) ? 4'd8 : diff5[3:0];
  assign emit_last = (emit_slot_r == SW'(nrgp_pkg::SLOT_COUNT - 1)) &&
                     (emit_chunk_r == 1'(CHUNKS - 1));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign load      = (state_r == ST_LD) && out_free;
  assign rd_en     = (state_r == ST_RD);
  assign rd_addr   = ADDR_W'(32'(emit_slot_r) * CHUNKS + 32'(emit_chunk_r));

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      text_m[j*8 +: 8] = (4'(j) < cnt) ? rd_data[j*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire && in_ch.batch_end) state_nxt = ST_CLEAR;
      ST_CLEAR: state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_LD;
      ST_LD:    if (load) state_nxt = emit_last ? ST_IDLE : ST_RD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  nrgp_slot_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_lane (app_len[2:0]),
    .wr_byte (c),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= nrgp_pkg::KIND_NONE;
      hdr_r   <= '0;
      pos_r   <= '0;
      chk_r   <= 1'b0;
      rmc_r   <= 1'b0;
      gga_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        kind_r <= nrgp_pkg::KIND_NONE;
        hdr_r  <= '0;
        pos_r  <= '0;
        chk_r  <= 1'b0;
        rmc_r  <= 1'b0;
        gga_r  <= 1'b0;
      end else begin
        kind_r <= kind_nxt;
        hdr_r  <= hdr_nxt;
        pos_r  <= pos_nxt;
        chk_r  <= chk_nxt;
        rmc_r  <= rmc_nxt;
        gga_r  <= gga_nxt;
      end
    end
  end

  // slot lengths and truncation flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < nrgp_pkg::SLOT_COUNT; s++) begin
        slot_len_r[s] <= '0;
        slot_ovf_r[s] <= 1'b0;
      end
    end else if (state_r == ST_CLEAR) begin
      for (int s = 0; s < nrgp_pkg::SLOT_COUNT; s++) begin
        if ((rmc_r && !gga_r && ((s >= 6 && s <= 8) || s >= 11)) ||
            (gga_r && !rmc_r && (s == 0 || s == 9 || s == 10))) begin
          slot_len_r[s] <= '0;
          slot_ovf_r[s] <= 1'b0;
        end
      end
    end else begin
      if (clr_en) begin
        slot_len_r[clr_sel.slot] <= '0;
        slot_ovf_r[clr_sel.slot] <= 1'b0;
      end
      if (app_en) begin
        if (app_room) slot_len_r[app_sel.slot] <= app_len + LEN_W'(1);
        else          slot_ovf_r[app_sel.slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_slot_r  <= '0;
      emit_chunk_r <= 1'b0;
    end else if (state_r == ST_CLEAR) begin
      emit_slot_r  <= '0;
      emit_chunk_r <= 1'b0;
    end else if (load) begin
      if (emit_chunk_r == 1'(CHUNKS - 1)) begin
        emit_chunk_r <= 1'b0;
        emit_slot_r  <= emit_slot_r + SW'(1);
      end else begin
        emit_chunk_r <= emit_chunk_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_slot_r  <= emit_slot_r;
      out_chunk_r <= emit_chunk_r;
      out_text_r  <= text_m;
      out_bytes_r <= cnt;
      out_trunc_r <= slot_ovf_r[emit_slot_r];
      out_last_r  <= emit_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.slot_index     = out_slot_r;
  assign out_ch.chunk_number   = out_chunk_r;
  assign out_ch.chunk_text     = out_text_r;
  assign out_ch.chunk_bytes    = out_bytes_r;
  assign out_ch.slot_truncated = out_trunc_r;
  assign out_ch.record_last    = out_last_r;

`ifndef NO_ASSERTIONS
  a_end_to_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.batch_end |=> state_r == ST_CLEAR)
    else $error("batch end did not start record emission");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |->
      out_slot_r == SW'(nrgp_pkg::SLOT_COUNT - 1) && out_chunk_r == 1'(CHUNKS - 1))
    else $error("record_last on a chunk other than the final one");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_bytes_r <= 4'd8)
    else $error("chunk byte count above eight");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("slot store written during emission");

  a_trunc_full: assert property (@(posedge clk) disable iff (!rst_n)
    load && slot_ovf_r[emit_slot_r] |-> 32'(len_e) == SLOT_CHARS)
    else $error("truncated slot is not full");
`endif

endmodule
